>>> sv/bitmap_page_allocator_macros.svh
// Assertion macros for the bitmap page allocator checker.
// Used by bpa_checker.sv; expects signals named clk and arst_n in scope.
`ifndef BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define BPA_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bitmap page allocator check failed");

// next-cycle implication, disabled during reset
`define BPA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bitmap page allocator check failed");

`endif

>>> sv/bpa_pkg.sv
// Shared types and constants for the bitmap page allocator.
// No dependencies; imported by bpa_ram, bitmap_page_allocator and bpa_checker.
package bpa_pkg;

	// field widths
	localparam int CFG_W  = 13;
	localparam int ADDR_W = 32;
	localparam int KIND_W = 2;

	// bitmap word and scan chunk geometry
	localparam int WORD_BITS   = 64;
	localparam int CHUNK_BITS  = 8;
	localparam int CHUNK_IDX_W = $clog2(WORD_BITS / CHUNK_BITS);

	// defaults for top-level parameters
	localparam int NUM_BLOCKS_DEF  = 4096;
	localparam int BLOCK_BYTES_DEF = 4096;

	// reset value of the managed block count
	localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

	typedef enum logic [KIND_W-1:0] {
		KIND_ALLOC = 2'd0,
		KIND_FREE  = 2'd1,
		KIND_MARK  = 2'd2,
		KIND_QUERY = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		S_CLEAR = 3'd0,
		S_IDLE  = 3'd1,
		S_RD    = 3'd2,
		S_WR    = 3'd3,
		S_SCAN  = 3'd4,
		S_QBIT  = 3'd5,
		S_RESP  = 3'd6
	} state_t;

endpackage

>>> sv/bpa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on bpa_pkg only for the default word width.
module bpa_ram #(
	parameter int WIDTH = bpa_pkg::WORD_BITS,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	import bpa_pkg::*;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/bitmap_page_allocator.sv
// Bitmap page allocator: one used bit per block, 64-bit words in one RAM, first-fit search.
// Free/query: a RAM read, then a write or a bit check; outside the store, straight to the result.
// Mark range: a read and a write per 64-bit word touched. Allocate: per word scanned, one RAM
// read, then 8 bits per cycle through the run finder; a found run is then marked likewise.
// One item at a time; input stalls until the result is in the output register.
// Reset: asynchronous; a clearing pass then zeroes each bitmap word before requests are taken.
module bitmap_page_allocator #(
	parameter int NUM_BLOCKS  = bpa_pkg::NUM_BLOCKS_DEF,
	parameter int BLOCK_BYTES = bpa_pkg::BLOCK_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration write channel
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bpa_pkg::CFG_W-1:0]   blocks_in_use,
	// request channel
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [bpa_pkg::KIND_W-1:0]  kind,
	input  logic [bpa_pkg::ADDR_W-1:0]  address,
	input  logic [bpa_pkg::ADDR_W-1:0]  end_address,
	input  logic [bpa_pkg::CFG_W-1:0]   count,
	// result channel
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [bpa_pkg::ADDR_W-1:0]  alloc_address,
	output logic                        success,
	output logic                        taken
);
	import bpa_pkg::*;

	localparam int SHIFT = $clog2(BLOCK_BYTES);
	localparam int WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int BOFF  = $clog2(WORD_BITS);
	localparam int BW    = ($clog2(NUM_BLOCKS) + 1 > WW + BOFF) ?
		$clog2(NUM_BLOCKS) + 1 : WW + BOFF;
	localparam int XW    = (BW > CFG_W) ? BW : CFG_W;
	localparam int RUN_W = CFG_W + 1;
	localparam int LANE_W = $clog2(CHUNK_BITS);

	// control registers
	state_t             state_q, state_d;
	logic [WW-1:0]      w_q;
	logic               out_valid_q;
	logic [CFG_W-1:0]   blocks_q;

	// work registers
	kind_t              op_q;
	logic [BW-1:0]      lo_q, hi_q, limit_q;
	logic               set_q;
	logic [CHUNK_IDX_W-1:0] c_q;
	logic [RUN_W-1:0]   run_q;
	logic [CFG_W-1:0]   count_q;
	logic [ADDR_W-1:0]  res_addr_q;
	logic               res_ok_q, res_taken_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic               out_ok_q, out_taken_q;

	// RAM port
	logic                 ram_we, ram_re;
	logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

	bpa_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(WORDS),
		.AW   (WW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(w_q),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(w_q),
		.rdata(ram_rdata)
	);

	// request decode
	logic               accept;
	kind_t              kind_in;
	logic [ADDR_W-1:0]  blk_addr;
	logic [ADDR_W:0]    stop_raw, stop_clip;
	logic [BW-1:0]      limit_in, lo_in, hi_in;
	logic               free_ok, mark_ok, query_ok, alloc_ok;

	always_comb begin
		kind_in   = kind_t'(kind);
		accept    = in_valid && (state_q == S_IDLE);
		blk_addr  = address >> SHIFT;
		stop_raw  = {1'b0, end_address >> SHIFT} +
			(ADDR_W + 1)'(end_address[SHIFT-1:0] != '0);
		stop_clip = (stop_raw > (ADDR_W + 1)'(NUM_BLOCKS)) ?
			(ADDR_W + 1)'(NUM_BLOCKS) : stop_raw;
		limit_in  = (XW'(blocks_q) > XW'(NUM_BLOCKS)) ? BW'(NUM_BLOCKS) : BW'(blocks_q);
		free_ok   = blk_addr < ADDR_W'(NUM_BLOCKS);
		mark_ok   = {1'b0, blk_addr} < stop_clip;
		query_ok  = address < ADDR_W'(NUM_BLOCKS);
		alloc_ok  = (count != '0) && (limit_in > BW'(1));
		case (kind_in)
			KIND_FREE: begin
				lo_in = BW'(blk_addr);
				hi_in = BW'(blk_addr) + 1'b1;
			end
			KIND_MARK: begin
				lo_in = BW'(blk_addr);
				hi_in = BW'(stop_clip);
			end
			KIND_QUERY: begin
				lo_in = BW'(address);
				hi_in = BW'(address) + 1'b1;
			end
			default: begin
				lo_in = '0;
				hi_in = '0;
			end
		endcase
	end

	// read-modify-write mask for the current word
	logic [BW-1:0]        hi_last;
	logic [WW-1:0]        lo_word, hi_word;
	logic [BOFF-1:0]      lo_off, hi_off;
	logic [WORD_BITS-1:0] rmw_mask, rmw_word;
	logic                 rmw_last;

	always_comb begin
		hi_last  = hi_q - 1'b1;
		lo_word  = lo_q[BOFF +: WW];
		hi_word  = hi_last[BOFF +: WW];
		lo_off   = (w_q == lo_word) ? lo_q[BOFF-1:0] : '0;
		hi_off   = (w_q == hi_word) ? hi_last[BOFF-1:0] : '1;
		rmw_mask = ({WORD_BITS{1'b1}} << lo_off) &
			({WORD_BITS{1'b1}} >> (BOFF'(WORD_BITS - 1) - hi_off));
		rmw_word = set_q ? (ram_rdata | rmw_mask) : (ram_rdata & ~rmw_mask);
		rmw_last = (w_q == hi_word);
	end

	// run finder: one chunk of the current word per cycle
	logic [BW-1:0]         base, rem, hit_blk, first_blk;
	logic [CHUNK_BITS-1:0] chunk, lane_free, hit_vec;
	logic [RUN_W-1:0]      need, run_next;
	logic                  any_used, hit, scan_end;
	logic [LANE_W-1:0]     last_used, hit_lane;

	always_comb begin
		base  = BW'({w_q, c_q, LANE_W'(0)});
		rem   = limit_q - base;
		chunk = ram_rdata[{c_q, LANE_W'(0)} +: CHUNK_BITS];
		for (int j = 0; j < CHUNK_BITS; j++) begin
			lane_free[j] = !chunk[j] && (rem > BW'(j)) && !((base == '0) && (j == 0));
		end
	end

	always_comb begin
		need      = RUN_W'(count_q) - run_q;
		any_used  = 1'b0;
		last_used = '0;
		hit_vec   = '0;
		for (int j = 0; j < CHUNK_BITS; j++) begin
			if (lane_free[j]) begin
				if (!any_used) begin
					hit_vec[j] = (need == RUN_W'(j + 1));
				end else begin
					hit_vec[j] = (RUN_W'(count_q) == (RUN_W'(j) - RUN_W'(last_used)));
				end
			end else begin
				any_used  = 1'b1;
				last_used = LANE_W'(j);
			end
		end
		run_next = any_used ? RUN_W'(LANE_W'(CHUNK_BITS - 1) - last_used) :
			run_q + RUN_W'(CHUNK_BITS);
	end

	// lowest hitting lane
	always_comb begin
		hit_lane = '0;
		for (int j = CHUNK_BITS - 1; j >= 0; j--) begin
			if (hit_vec[j]) begin
				hit_lane = LANE_W'(j);
			end
		end
		hit       = |hit_vec;
		hit_blk   = base + BW'(hit_lane);
		first_blk = hit_blk + 1'b1 - BW'(count_q);
		scan_end  = rem <= BW'(CHUNK_BITS);
	end

	logic can_load;
	assign can_load = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (w_q == WW'(WORDS - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					case (kind_in)
						KIND_ALLOC: state_d = alloc_ok ? S_RD : S_RESP;
						KIND_FREE:  state_d = free_ok ? S_RD : S_RESP;
						KIND_MARK:  state_d = mark_ok ? S_RD : S_RESP;
						default:    state_d = query_ok ? S_RD : S_RESP;
					endcase
				end
			end
			S_RD: begin
				case (op_q)
					KIND_QUERY: state_d = S_QBIT;
					KIND_ALLOC: state_d = S_SCAN;
					default:    state_d = S_WR;
				endcase
			end
			S_WR: begin
				state_d = rmw_last ? S_RESP : S_RD;
			end
			S_SCAN: begin
				if (hit) begin
					state_d = S_RD;
				end else if (scan_end) begin
					state_d = S_RESP;
				end else if (c_q == '1) begin
					state_d = S_RD;
				end
			end
			S_QBIT: state_d = S_RESP;
			S_RESP: begin
				if (can_load) state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall  = (state_q != S_IDLE);
		ram_re    = (state_q == S_RD);
		ram_we    = (state_q == S_CLEAR) || (state_q == S_WR);
		ram_wdata = (state_q == S_CLEAR) ? '0 : rmw_word;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			w_q         <= '0;
			out_valid_q <= 1'b0;
			blocks_q    <= CFG_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_valid) blocks_q <= blocks_in_use;
			// word pointer
			case (state_q)
				S_CLEAR: w_q <= w_q + 1'b1;
				S_IDLE: begin
					if (accept) w_q <= (kind_in == KIND_ALLOC) ? '0 : lo_in[BOFF +: WW];
				end
				S_WR: begin
					if (!rmw_last) w_q <= w_q + 1'b1;
				end
				S_SCAN: begin
					if (hit) begin
						w_q <= first_blk[BOFF +: WW];
					end else if (c_q == '1) begin
						w_q <= w_q + 1'b1;
					end
				end
				default: w_q <= w_q;
			endcase
			// result beat
			if (state_q == S_RESP && can_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// work and result registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q        <= kind_in;
					lo_q        <= lo_in;
					hi_q        <= hi_in;
					set_q       <= (kind_in == KIND_MARK);
					limit_q     <= limit_in;
					count_q     <= count;
					c_q         <= '0;
					run_q       <= '0;
					res_addr_q  <= '0;
					res_ok_q    <= 1'b0;
					res_taken_q <= (kind_in == KIND_QUERY) && !query_ok;
				end
			end
			S_SCAN: begin
				if (hit) begin
					op_q       <= KIND_MARK;
					lo_q       <= first_blk;
					hi_q       <= hit_blk + 1'b1;
					set_q      <= 1'b1;
					res_addr_q <= ADDR_W'(first_blk) << SHIFT;
					res_ok_q   <= 1'b1;
				end else begin
					c_q   <= c_q + 1'b1;
					run_q <= run_next;
				end
			end
			S_QBIT: res_taken_q <= ram_rdata[lo_q[BOFF-1:0]];
			S_RESP: begin
				if (can_load) begin
					out_addr_q  <= res_addr_q;
					out_ok_q    <= res_ok_q;
					out_taken_q <= res_taken_q;
				end
			end
			default: c_q <= c_q;
		endcase
	end

	assign cfg_ready     = 1'b1;
	assign out_valid     = out_valid_q;
	assign alloc_address = out_addr_q;
	assign success       = out_ok_q;
	assign taken         = out_taken_q;

endmodule

>>> sv/bpa_checker.sv
// Port-level checks for the bitmap page allocator, bound to the top level.
// Depends on bpa_pkg and bitmap_page_allocator_macros.svh.
`include "bitmap_page_allocator_macros.svh"

module bpa_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       cfg_valid,
	input logic                       cfg_ready,
	input logic [bpa_pkg::CFG_W-1:0]  blocks_in_use,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic [bpa_pkg::KIND_W-1:0] kind,
	input logic [bpa_pkg::ADDR_W-1:0] address,
	input logic [bpa_pkg::ADDR_W-1:0] end_address,
	input logic [bpa_pkg::CFG_W-1:0]  count,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [bpa_pkg::ADDR_W-1:0] alloc_address,
	input logic                       success,
	input logic                       taken
);
	import bpa_pkg::*;

	// one request in flight: busy right after an accepted beat
	`BPA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

	// an allocate result never carries a query bit
	`BPA_ASSERT_SAME(a_alloc_not_query, out_valid && success, !taken)

	// failed allocate and non-allocate results report address zero
	`BPA_ASSERT_SAME(a_fail_zero_addr, out_valid && !success, alloc_address == '0)

	// a stalled result beat holds
	`BPA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(alloc_address) && $stable(success) && $stable(taken))

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (.*);

>>> sim/bitmap_page_allocator_tb.sv
// Self-checking testbench for bitmap_page_allocator: directed and random allocate, free,
// mark-range and query beats, with idle/stall phases checked against an in-bench bitmap.
// Depends on bpa_pkg and the bitmap_page_allocator RTL only.
`timescale 1ns / 100ps

module bitmap_page_allocator_tb;
	import bpa_pkg::*;

	localparam int NBLK        = NUM_BLOCKS_DEF;
	localparam int BBYTES      = BLOCK_BYTES_DEF;
	// longest legal quiet stretch: long hold + full scan with marking + clearing pass
	localparam int QUIET_LIMIT = 5000;
	localparam int LONG_HOLD   = 400;
	localparam int TAIL_CYCLES = 50;

	typedef struct {
		kind_t              kind;
		logic [ADDR_W-1:0]  address;
		logic [ADDR_W-1:0]  end_address;
		logic [CFG_W-1:0]   count;
	} request_t;

	typedef struct {
		logic [ADDR_W-1:0]  alloc_address;
		logic               success;
		logic               taken;
	} outcome_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CFG_W-1:0]   blocks_in_use = CFG_RESET;
	logic               in_valid = 1'b0;
	logic               in_stall;
	kind_t              kind = KIND_QUERY;
	logic [ADDR_W-1:0]  address = '0;
	logic [ADDR_W-1:0]  end_address = '0;
	logic [CFG_W-1:0]   count = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [ADDR_W-1:0]  alloc_address;
	logic               success;
	logic               taken;

	// bench copy of the block state
	bit                 used_map [NBLK];
	int unsigned        managed_blocks = CFG_RESET;

	request_t           request_q [$];
	outcome_t           outcome_q [$];
	request_t           cur_req;
	int unsigned        mismatches = 0;

	// traffic shaping, set per phase
	int unsigned        send_idle_pct = 0;
	int unsigned        stall_pct = 0;
	bit                 long_hold_go = 1'b0;
	bit                 long_hold_done = 1'b0;
	int unsigned        hold_left = 0;

	bitmap_page_allocator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.blocks_in_use (blocks_in_use),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.address       (address),
		.end_address   (end_address),
		.count         (count),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.alloc_address (alloc_address),
		.success       (success),
		.taken         (taken)
	);

	always #1 clk = ~clk;

	// apply one request to the bench bitmap and return the result beat it should produce
	function automatic outcome_t apply_request(request_t r);
		outcome_t o;
		longint unsigned lim, run, i, k, first, stop;
		o.alloc_address = '0;
		o.success = 1'b0;
		o.taken = 1'b0;
		case (r.kind)
			KIND_ALLOC: begin
				lim = (managed_blocks > NBLK) ? NBLK : managed_blocks;
				run = 0;
				// first fit from block 1; block 0 is never handed out
				if (r.count != 0) begin
					for (i = 1; i < lim && !o.success; i++) begin
						if (used_map[i]) begin
							run = 0;
						end else begin
							run++;
							if (run == r.count) begin
								first = i + 1 - r.count;
								for (k = first; k <= i; k++) used_map[k] = 1'b1;
								o.alloc_address = 32'(first * BBYTES);
								o.success = 1'b1;
							end
						end
					end
				end
			end
			KIND_FREE: begin
				first = r.address / BBYTES;
				if (first < NBLK) used_map[first] = 1'b0;
			end
			KIND_MARK: begin
				// start rounds down, end rounds up; blocks past the store are dropped
				first = r.address / BBYTES;
				stop = r.end_address / BBYTES + ((r.end_address % BBYTES) != 0);
				if (stop > NBLK) stop = NBLK;
				for (k = first; k < stop; k++) used_map[k] = 1'b1;
			end
			default: begin
				o.taken = (r.address >= NBLK) ? 1'b1 : used_map[r.address];
			end
		endcase
		return o;
	endfunction

	function automatic request_t random_request(int unsigned span);
		request_t r;
		int unsigned pick, blk, len;
		r.kind = KIND_QUERY;
		r.address = $urandom();
		r.end_address = $urandom();
		r.count = CFG_W'($urandom());
		pick = $urandom_range(99);
		if (pick < 36) begin
			r.kind = KIND_ALLOC;
			pick = $urandom_range(99);
			// mostly short runs; some up to two past the span; a few raw 13-bit counts
			if (pick < 60) r.count = CFG_W'($urandom_range(4, 1));
			else if (pick < 85) r.count = CFG_W'($urandom_range(32, 1));
			else if (pick < 95) r.count = CFG_W'($urandom_range(span + 2, 0));
		end else if (pick < 66) begin
			r.kind = KIND_FREE;
			if ($urandom_range(9) != 0)
				r.address = $urandom_range(span) * BBYTES + $urandom_range(BBYTES - 1);
		end else if (pick < 78) begin
			r.kind = KIND_MARK;
			if ($urandom_range(9) != 0) begin
				blk = $urandom_range(span);
				len = $urandom_range(12);
				r.address = blk * BBYTES + $urandom_range(BBYTES - 1);
				r.end_address = (blk + len) * BBYTES
					+ ($urandom_range(1) ? 0 : $urandom_range(BBYTES - 1));
			end
		end else begin
			if ($urandom_range(9) != 0) r.address = $urandom_range(span + 2);
		end
		return r;
	endfunction

	task automatic push_req(kind_t k, logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] e,
			logic [CFG_W-1:0] c);
		request_t r;
		r.kind = k;
		r.address = a;
		r.end_address = e;
		r.count = c;
		request_q.push_back(r);
	endtask

	task automatic queue_random(int n, int unsigned span);
		repeat (n) request_q.push_back(random_request(span));
	endtask

	// wait until every request is sent and every result beat is back
	task automatic drain();
		while (request_q.size() != 0 || in_valid || outcome_q.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	// write the managed block count (block idle), then set the traffic mix
	task automatic begin_phase(logic [CFG_W-1:0] v, int unsigned send_pct,
			int unsigned recv_pct);
		@(posedge clk);
		cfg_valid <= 1'b1;
		blocks_in_use <= v;
		do @(posedge clk); while (!cfg_ready);
		managed_blocks = v;
		cfg_valid <= 1'b0;
		@(negedge clk);
		send_idle_pct = send_pct;
		stall_pct = recv_pct;
	endtask

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) outcome_q.push_back(apply_request(cur_req));
			if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cur_req = request_q.pop_front();
				kind <= cur_req.kind;
				address <= cur_req.address;
				end_address <= cur_req.end_address;
				count <= cur_req.count;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result-side stall, with one long hold-off to back the block up
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (hold_left != 0) begin
				hold_left--;
			end else if (long_hold_go && !long_hold_done) begin
				hold_left = LONG_HOLD;
				long_hold_done = 1'b1;
			end
			out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
		end
	end

	// result monitor
	always @(posedge clk) begin
		outcome_t exp_o;
		if (arst_n && out_valid && !out_stall) begin
			if (outcome_q.size() == 0) begin
				$display("%0t: result beat with none expected: addr %h ok %b taken %b",
					$time, alloc_address, success, taken);
				mismatches++;
			end else begin
				exp_o = outcome_q.pop_front();
				if (alloc_address !== exp_o.alloc_address) begin
					$display("%0t: alloc_address expected %h got %h",
						$time, exp_o.alloc_address, alloc_address);
					mismatches++;
				end
				if (success !== exp_o.success) begin
					$display("%0t: success expected %b got %b", $time, exp_o.success, success);
					mismatches++;
				end
				if (taken !== exp_o.taken) begin
					$display("%0t: taken expected %b got %b", $time, exp_o.taken, taken);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles with no handshake on any channel
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// stimulus sequence
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset count of 4096 managed blocks, no idling
		push_req(KIND_QUERY, 32'd0, 32'd0, 13'd0);
		push_req(KIND_QUERY, 32'd4095, 32'd0, 13'd0);
		push_req(KIND_QUERY, 32'd4096, 32'd0, 13'd0);       // past the store reads taken
		push_req(KIND_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 13'd0);
		push_req(KIND_ALLOC, 32'd0, 32'd0, 13'd0);          // zero count fails
		push_req(KIND_ALLOC, 32'hFFFF_FFFF, 32'd0, 13'd1);  // block 1, never block 0
		push_req(KIND_ALLOC, 32'd0, 32'd0, 13'd3);
		push_req(KIND_FREE, 32'h0000_1005, 32'd0, 13'd0);
		push_req(KIND_ALLOC, 32'd0, 32'd0, 13'd2);          // hole at block 1 too short
		push_req(KIND_ALLOC, 32'd0, 32'd0, 13'd1);
		push_req(KIND_MARK, 32'd0, 32'd0, 13'd0);           // empty range
		push_req(KIND_MARK, 32'h0002_0000, 32'h0001_0000, 13'd0); // reversed range
		push_req(KIND_MARK, 32'h0000_7FFF, 32'h0000_9001, 13'd0); // rounds out to 7..9
		push_req(KIND_QUERY, 32'd9, 32'd0, 13'd0);
		push_req(KIND_QUERY, 32'd10, 32'd0, 13'd0);
		push_req(KIND_MARK, 32'hFFFF_F000, 32'hFFFF_FFFF, 13'd0); // wholly past the store
		push_req(KIND_MARK, 32'h00FF_F000, 32'hFFFF_FFFF, 13'd0); // end clamps to store
		push_req(KIND_QUERY, 32'd4095, 32'd0, 13'd0);
		push_req(KIND_ALLOC, 32'd0, 32'd0, 13'h1FFF);
		push_req(KIND_ALLOC, 32'd0, 32'd0, 13'd4096);
		push_req(KIND_FREE, 32'hFFFF_FFFF, 32'd0, 13'd0);   // past the store, ignored
		push_req(KIND_MARK, 32'd0, 32'h0000_1000, 13'd0);   // block 0 only
		push_req(KIND_QUERY, 32'd0, 32'd0, 13'd0);
		push_req(KIND_FREE, 32'h00FF_F800, 32'd0, 13'd0);
		drain();

		// small pool, no idling; receiver holds off long while requests keep coming
		begin_phase(13'd64, 0, 0);
		queue_random(150, 64);
		long_hold_go = 1'b1;
		drain();

		// count above the store clamps the search
		begin_phase(13'h1FFF, 85, 0);
		queue_random(120, 300);
		drain();

		// nothing managed: every allocate fails
		begin_phase(13'd0, 0, 85);
		queue_random(60, 64);
		drain();

		// only block 0 managed: search range is empty
		begin_phase(13'd1, 31, 31);
		queue_random(40, 64);
		drain();

		begin_phase(13'd200, 0, 85);
		queue_random(150, 200);
		drain();

		begin_phase(13'd4096, 31, 31);
		queue_random(150, 300);
		drain();

		begin_phase(13'($urandom_range(300, 2)), 85, 0);
		queue_random(120, managed_blocks);
		drain();

		// no idling, with a full pause in the middle
		begin_phase(13'd128, 0, 0);
		queue_random(65, 128);
		drain();
		queue_random(65, 128);
		drain();

		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0 && outcome_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			if (outcome_q.size() != 0)
				$display("%0t: %0d result beats never arrived", $time, outcome_q.size());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

>>> bitmap_page_allocator.f
+incdir+sv
sv/bpa_pkg.sv
sv/bpa_ram.sv
sv/bitmap_page_allocator.sv
sv/bpa_checker.sv
sim/bitmap_page_allocator_tb.sv
